>>> sv/sccb_pkg.sv
// Package for the SSD command coalescing buffer.
// Holds widths, command and status codes and the command and status types; no dependencies.
package sccb_pkg;
   localparam int BUFFER_CAPACITY = 5;
   localparam int LBA_BITS = 10;
   localparam int DATA_BITS = 32;
   localparam int REG_BITS = 10;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_ERASE = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_DUMP = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_LBA = 2'd1;
   localparam logic [1:0] STATUS_BAD_ERASE = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LBA_UPPER = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_ERASE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ERASE = 2'd2;

   typedef enum logic [2:0] {
      CMD_NONE, CMD_LOAD, CMD_FILTER, CMD_SORT, CMD_MERGE, CMD_COMMIT, CMD_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
   } cmd_type;

   typedef struct packed {
      logic sort_done;
      logic merge_done;
      logic bad;
      logic flushed;
   } stat_type;
endpackage

>>> sv/sccb_datapath.sv
// Datapath of the coalescing buffer: entry store, work list, filter, sort and merge.
// Depends on sccb_pkg; steered by sccb_ctrl through cmd_type and stat_type.
module sccb_datapath #(
   parameter int BUFFER_CAPACITY = sccb_pkg::BUFFER_CAPACITY,
   parameter int LBA_BITS = sccb_pkg::LBA_BITS,
   parameter int DATA_BITS = sccb_pkg::DATA_BITS
) (
   input  logic clock,
   input  logic reset,
   input  sccb_pkg::cmd_type cmd,
   output sccb_pkg::stat_type stat,
   input  logic [1:0] kind,
   input  logic [LBA_BITS-1:0] lba,
   input  logic [31:0] value,
   input  logic [sccb_pkg::REG_BITS-1:0] lba_upper,
   input  logic [sccb_pkg::REG_BITS-1:0] min_erase,
   input  logic [sccb_pkg::REG_BITS-1:0] max_erase,
   input  logic [$clog2(BUFFER_CAPACITY+1)-1:0] rd_index,
   output logic [$clog2(BUFFER_CAPACITY+1)-1:0] count,
   output logic rd_erase,
   output logic [LBA_BITS-1:0] rd_lba,
   output logic [DATA_BITS-1:0] rd_value
);
   localparam int DEPTH = BUFFER_CAPACITY + 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int RW = $clog2(BUFFER_CAPACITY + 1);
   localparam int SW = (LBA_BITS > 32 ? LBA_BITS : 32) + 2;

   logic [BUFFER_CAPACITY-1:0] st_erase_ff;
   logic [LBA_BITS-1:0] st_lba_ff [BUFFER_CAPACITY];
   logic [DATA_BITS-1:0] st_val_ff [BUFFER_CAPACITY];
   logic [CW-1:0] st_cnt_ff;

   logic [DEPTH-1:0] w_erase_ff, w_live_ff;
   logic [LBA_BITS-1:0] w_lba_ff [DEPTH];
   logic [DATA_BITS-1:0] w_val_ff [DEPTH];
   logic bad_ff, flushed_ff, sorted_ff, merged_ff;
   logic [CW-1:0] m_ff;

   logic [SW-1:0] end_in;
   assign end_in = SW'(lba) + SW'(value) - SW'(1);
   logic bad_in;
   always_comb begin
      bad_in = 1'b0;
      if (kind == sccb_pkg::KIND_WRITE)
         bad_in = SW'(lba) > SW'(lba_upper);
      else
         bad_in = (value < 32'(min_erase)) || (value > 32'(max_erase))
                  || (SW'(lba) + SW'(value) > SW'(lba_upper) + SW'(1));
   end

   logic [SW-1:0] pe, ce;
   logic [SW-1:0] ms, cs;
   always_comb begin
      ms = SW'(w_lba_ff[m_ff[CW-1:0] - CW'(1)]);
      pe = ms + SW'(w_val_ff[m_ff - CW'(1)]);
      cs = SW'(w_lba_ff[m_ff]);
      ce = cs + SW'(w_val_ff[m_ff]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_cnt_ff <= '0;
         st_erase_ff <= '0;
      end else begin
         case (cmd.op)
            sccb_pkg::CMD_LOAD: begin
               bad_ff <= bad_in;
               flushed_ff <= 1'b0;
               sorted_ff <= 1'b0;
               merged_ff <= 1'b0;
               m_ff <= CW'(1);
               for (int i = 0; i < DEPTH; i++) begin
                  if (CW'(i) == st_cnt_ff) begin
                     w_erase_ff[i] <= kind == sccb_pkg::KIND_ERASE;
                     w_lba_ff[i] <= lba;
                     w_val_ff[i] <= DATA_BITS'(value);
                     w_live_ff[i] <= 1'b1;
                  end else if (i < BUFFER_CAPACITY) begin
                     w_erase_ff[i] <= st_erase_ff[i];
                     w_lba_ff[i] <= st_lba_ff[i];
                     w_val_ff[i] <= st_val_ff[i];
                     w_live_ff[i] <= CW'(i) < st_cnt_ff;
                  end else w_live_ff[i] <= 1'b0;
               end
            end
            sccb_pkg::CMD_FILTER: begin
               for (int i = 0; i < BUFFER_CAPACITY; i++)
                  if (CW'(i) < st_cnt_ff && !w_erase_ff[i]) begin
                     if (kind == sccb_pkg::KIND_WRITE && w_lba_ff[i] == lba)
                        w_live_ff[i] <= 1'b0;
                     if (kind == sccb_pkg::KIND_ERASE && w_lba_ff[i] >= lba
                         && SW'(w_lba_ff[i]) <= end_in && value != 0)
                        w_live_ff[i] <= 1'b0;
                  end
            end
            sccb_pkg::CMD_SORT: begin
               // One adjacent swap per cycle: live before dead, writes before
               // erases, erases by ascending start.
               logic sw;
               sw = 1'b0;
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (!sw && ((!w_live_ff[i] && w_live_ff[i+1]) || (w_live_ff[i]
                      && w_live_ff[i+1] && w_erase_ff[i] && (!w_erase_ff[i+1]
                      || w_lba_ff[i] > w_lba_ff[i+1])))) begin
                     sw = 1'b1;
                     w_live_ff[i] <= w_live_ff[i+1];
                     w_live_ff[i+1] <= w_live_ff[i];
                     w_erase_ff[i] <= w_erase_ff[i+1];
                     w_erase_ff[i+1] <= w_erase_ff[i];
                     w_lba_ff[i] <= w_lba_ff[i+1];
                     w_lba_ff[i+1] <= w_lba_ff[i];
                     w_val_ff[i] <= w_val_ff[i+1];
                     w_val_ff[i+1] <= w_val_ff[i];
                  end
               end
               if (!sw) sorted_ff <= 1'b1;
            end
            sccb_pkg::CMD_MERGE: begin
               if (m_ff >= CW'(DEPTH) || !w_live_ff[m_ff]) merged_ff <= 1'b1;
               else if (!w_erase_ff[m_ff] || !w_erase_ff[m_ff - CW'(1)])
                  m_ff <= m_ff + CW'(1);
               else if (cs <= pe) begin
                  if (ce - ms <= SW'(max_erase)) begin
                     if (ce > pe) w_val_ff[m_ff - CW'(1)] <= DATA_BITS'(ce - ms);
                     for (int i = 0; i < DEPTH - 1; i++)
                        if (CW'(i) >= m_ff) begin
                           w_live_ff[i] <= w_live_ff[i+1];
                           w_erase_ff[i] <= w_erase_ff[i+1];
                           w_lba_ff[i] <= w_lba_ff[i+1];
                           w_val_ff[i] <= w_val_ff[i+1];
                        end
                     w_live_ff[DEPTH-1] <= 1'b0;
                  end else if (ce > pe) begin
                     w_lba_ff[m_ff] <= LBA_BITS'(pe);
                     w_val_ff[m_ff] <= DATA_BITS'(ce - pe);
                     m_ff <= m_ff + CW'(1);
                  end else begin
                     for (int i = 0; i < DEPTH - 1; i++)
                        if (CW'(i) >= m_ff) begin
                           w_live_ff[i] <= w_live_ff[i+1];
                           w_erase_ff[i] <= w_erase_ff[i+1];
                           w_lba_ff[i] <= w_lba_ff[i+1];
                           w_val_ff[i] <= w_val_ff[i+1];
                        end
                     w_live_ff[DEPTH-1] <= 1'b0;
                  end
               end else m_ff <= m_ff + CW'(1);
            end
            sccb_pkg::CMD_COMMIT: begin
               if (w_live_ff[DEPTH-1]) begin
                  flushed_ff <= 1'b1;
                  st_cnt_ff <= '0;
               end else begin
                  st_cnt_ff <= CW'($countones(w_live_ff));
                  for (int i = 0; i < BUFFER_CAPACITY; i++) begin
                     st_erase_ff[i] <= w_erase_ff[i];
                     st_lba_ff[i] <= w_lba_ff[i];
                     st_val_ff[i] <= w_val_ff[i];
                  end
               end
            end
            sccb_pkg::CMD_CLEAR: st_cnt_ff <= '0;
            default: ;
         endcase
      end
   end

   assign stat.sort_done = sorted_ff;
   assign stat.merge_done = merged_ff;
   assign stat.bad = bad_ff;
   assign stat.flushed = flushed_ff;
   assign count = RW'(st_cnt_ff);
   assign rd_erase = st_erase_ff[rd_index];
   assign rd_lba = st_lba_ff[rd_index];
   assign rd_value = st_val_ff[rd_index];
endmodule

>>> sv/sccb_ctrl.sv
// Controller of the coalescing buffer: sequences one command and its results.
// Depends on sccb_pkg; drives sccb_datapath through cmd_type.
module sccb_ctrl #(
   parameter int BUFFER_CAPACITY = sccb_pkg::BUFFER_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_kind,
   output logic [1:0] kind,
   output sccb_pkg::cmd_type cmd,
   input  sccb_pkg::stat_type stat,
   input  logic [$clog2(BUFFER_CAPACITY+1)-1:0] count,
   output logic [$clog2(BUFFER_CAPACITY+1)-1:0] rd_index,
   output logic out_load,
   output logic out_entry,
   output logic out_last,
   input  logic rsp_stall,
   output logic rsp_valid
);
   localparam int CW = $clog2(BUFFER_CAPACITY + 1);
   localparam logic [3:0] S_IDLE = 4'd0, S_FILTER = 4'd1, S_SORT = 4'd2,
      S_MERGE = 4'd3, S_COMMIT = 4'd4, S_REPLY = 4'd5, S_DUMP = 4'd6,
      S_WAIT = 4'd7, S_LOAD = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] kind_ff;
   logic [CW-1:0] idx_ff;
   logic valid_ff;

   assign kind = kind_ff;
   assign rd_index = idx_ff;
   assign rsp_valid = valid_ff;
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd.op = sccb_pkg::CMD_NONE;
      out_load = 1'b0;
      out_entry = 1'b0;
      out_last = 1'b1;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            case (req_kind)
               sccb_pkg::KIND_WRITE, sccb_pkg::KIND_ERASE: begin
                  state_in = S_LOAD;
               end
               sccb_pkg::KIND_CLEAR: begin
                  cmd.op = sccb_pkg::CMD_CLEAR;
                  state_in = S_REPLY;
               end
               default: state_in = S_DUMP;
            endcase
         end
         S_LOAD: begin
            cmd.op = sccb_pkg::CMD_LOAD;
            state_in = S_FILTER;
         end
         S_FILTER: begin
            cmd.op = sccb_pkg::CMD_FILTER;
            state_in = stat.bad ? S_REPLY : S_SORT;
            if (stat.bad) cmd.op = sccb_pkg::CMD_NONE;
         end
         S_SORT: begin
            cmd.op = sccb_pkg::CMD_SORT;
            if (stat.sort_done) begin
               cmd.op = sccb_pkg::CMD_NONE;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            cmd.op = sccb_pkg::CMD_MERGE;
            if (stat.merge_done) begin
               cmd.op = sccb_pkg::CMD_COMMIT;
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: state_in = S_REPLY;
         S_REPLY: if (!valid_ff || !rsp_stall) begin
            out_load = 1'b1;
            state_in = S_WAIT;
         end
         S_DUMP: if (!valid_ff || !rsp_stall) begin
            out_load = 1'b1;
            out_entry = count != '0;
            out_last = count == '0 || idx_ff + CW'(1) >= count;
            if (out_last) state_in = S_WAIT;
         end
         S_WAIT: if (!valid_ff || !rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         idx_ff <= '0;
         kind_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && req_valid) begin
            kind_ff <= req_kind;
            idx_ff <= '0;
         end
         if (out_load) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
         if (state_ff == S_DUMP && out_load) idx_ff <= idx_ff + CW'(1);
      end
   end
endmodule

>>> sv/ssd_command_coalescing_buffer.sv
// Top level of the SSD command coalescing buffer.
// Depends on sccb_pkg, sccb_ctrl and sccb_datapath.
//
// Commands arrive on the req_ channel (valid/stall) and each gives one or more
// result transfers on the rsp_ channel; rsp_last marks the final one.
// An accepted write or erase is loaded, filtered, sorted and merged in the
// work list and committed before its result is given; the sort makes one swap
// per cycle and the merge takes one work entry per cycle. A rejected write or
// erase answers after the filter step, a clear once the buffer is emptied, and
// a dump gives its first entry and then one further entry per cycle while rsp_stall is low.
// One command is handled at a time; req_stall is high until its results have
// all been transferred. A held result waits in the output register while
// rsp_stall is high. Reset empties the buffer and loads the register defaults
// (upper address 99, minimum erase 1, maximum erase 10).
// Registers are written through csr_write_enable, csr_index and csr_write_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce it.
module ssd_command_coalescing_buffer #(
   parameter int BUFFER_CAPACITY = sccb_pkg::BUFFER_CAPACITY,
   parameter int LBA_BITS = sccb_pkg::LBA_BITS,
   parameter int DATA_BITS = sccb_pkg::DATA_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [sccb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sccb_pkg::REG_BITS-1:0] csr_write_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_kind,
   input  logic [LBA_BITS-1:0] req_lba,
   input  logic [31:0] req_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic rsp_flushed,
   output logic rsp_entry_valid,
   output logic rsp_entry_kind,
   output logic [LBA_BITS-1:0] rsp_entry_lba,
   output logic [DATA_BITS-1:0] rsp_entry_value,
   output logic rsp_last
);
   localparam int CW = $clog2(BUFFER_CAPACITY + 1);

   logic [sccb_pkg::REG_BITS-1:0] upper_ff, min_ff, max_ff;
   logic [LBA_BITS-1:0] lba_ff;
   logic [31:0] value_ff;
   logic [1:0] kind;
   sccb_pkg::cmd_type cmd;
   sccb_pkg::stat_type stat;
   logic [CW-1:0] count, rd_index;
   logic rd_erase, out_load, out_entry, out_last;
   logic [LBA_BITS-1:0] rd_lba;
   logic [DATA_BITS-1:0] rd_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= sccb_pkg::REG_BITS'(99);
         min_ff <= sccb_pkg::REG_BITS'(1);
         max_ff <= sccb_pkg::REG_BITS'(10);
      end else if (csr_write_enable) begin
         case (csr_index)
            sccb_pkg::CSR_LBA_UPPER: upper_ff <= csr_write_data;
            sccb_pkg::CSR_MIN_ERASE: min_ff <= csr_write_data;
            sccb_pkg::CSR_MAX_ERASE: max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         lba_ff <= req_lba;
         value_ff <= req_value;
      end
      if (out_load) begin
         rsp_status <= stat.bad ? (kind == sccb_pkg::KIND_WRITE ?
            sccb_pkg::STATUS_BAD_LBA : sccb_pkg::STATUS_BAD_ERASE) : sccb_pkg::STATUS_OK;
         if (kind == sccb_pkg::KIND_CLEAR || kind == sccb_pkg::KIND_DUMP)
            rsp_status <= sccb_pkg::STATUS_OK;
         rsp_flushed <= (kind == sccb_pkg::KIND_WRITE || kind == sccb_pkg::KIND_ERASE)
                        && !stat.bad && stat.flushed;
         rsp_entry_valid <= out_entry;
         rsp_entry_kind <= out_entry && rd_erase;
         rsp_entry_lba <= out_entry ? rd_lba : '0;
         rsp_entry_value <= out_entry ? rd_value : '0;
         rsp_last <= out_last;
      end
   end

   sccb_ctrl #(.BUFFER_CAPACITY(BUFFER_CAPACITY)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .kind, .cmd, .stat,
      .count, .rd_index, .out_load, .out_entry, .out_last, .rsp_stall, .rsp_valid
   );

   sccb_datapath #(
      .BUFFER_CAPACITY(BUFFER_CAPACITY), .LBA_BITS(LBA_BITS), .DATA_BITS(DATA_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .stat, .kind, .lba(lba_ff), .value(value_ff),
      .lba_upper(upper_ff), .min_erase(min_ff), .max_erase(max_ff),
      .rd_index, .count, .rd_erase, .rd_lba, .rd_value
   );
endmodule
